/* design/mrm_pkg.sv */
`timescale 1ns / 1ps

package mrm_pkg;

  localparam int unsigned RING_WORDS_DEF   = 8192;
  localparam int unsigned NOTICE_DEPTH_DEF = 8;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned HALF_W   = 16;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned VB_W     = 3;
  localparam int unsigned SLOT_W   = 15;
  localparam int unsigned CALC_W   = 17;

  localparam int unsigned WORD_BYTES = 4;
  localparam int unsigned WORD_SHIFT = 2;
  localparam int unsigned ROUND_UP   = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_SEND_BEGIN = 3'd0,
    KIND_SEND_WORD  = 3'd1,
    KIND_PEEK       = 3'd2,
    KIND_RECV_BEGIN = 3'd3,
    KIND_RECV_WORD  = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_RETRY    = 3'd1,
    ST_TOO_BIG  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_MISMATCH = 3'd4,
    ST_SEQ      = 3'd5
  } status_e;

  typedef struct packed {
    logic push;
    logic pop;
  } nq_ctrl_t;

  // A slot is one header word plus the payload rounded up to whole words.
  function automatic logic [SLOT_W-1:0] slot_words(input logic [HALF_W-1:0] len);
    logic [CALC_W-1:0] r;
    r = CALC_W'(len) + CALC_W'(ROUND_UP);
    return SLOT_W'(r >> WORD_SHIFT) + SLOT_W'(1);
  endfunction

endpackage

/* design/mrm_if.sv */
`timescale 1ns / 1ps

interface mrm_in_if;
  import mrm_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [HALF_W-1:0]   msg_type;
  logic [HALF_W-1:0]   length;
  logic [HALF_W-1:0]   max_len;
  logic [WORD_W-1:0]   data;

  modport source (output valid, kind, msg_type, length, max_len, data, input ready);
  modport sink   (input valid, kind, msg_type, length, max_len, data, output ready);
endinterface

interface mrm_out_if;
  import mrm_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HALF_W-1:0]   msg_type_res;
  logic [HALF_W-1:0]   length_res;
  logic [WORD_W-1:0]   data_res;
  logic [VB_W-1:0]     valid_bytes;
  logic                last;

  modport source (output valid, status, msg_type_res, length_res, data_res, valid_bytes, last,
                  input ready);
  modport sink   (input valid, status, msg_type_res, length_res, data_res, valid_bytes, last,
                  output ready);
endinterface

/* design/mrm_ring_ram.sv */
`timescale 1ns / 1ps

module mrm_ring_ram #(
  parameter int unsigned WORDS = mrm_pkg::RING_WORDS_DEF,
  parameter int unsigned AW    = $clog2(mrm_pkg::RING_WORDS_DEF)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [mrm_pkg::WORD_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [mrm_pkg::WORD_W-1:0] rdata_o
);
  import mrm_pkg::*;

  logic [WORD_W-1:0] mem_q [WORDS];
  logic [WORD_W-1:0] rd_q;
  logic [WORD_W-1:0] byp_data_q;
  logic              byp_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q       <= mem_q[raddr_i];
      byp_data_q <= wdata_i;
    end
  end

  // A read that meets a write to the same word in one cycle returns the new word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (re_i) begin
      byp_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = byp_q ? byp_data_q : rd_q;

endmodule

/* design/mrm_notice_fifo.sv */
`timescale 1ns / 1ps

module mrm_notice_fifo #(
  parameter int unsigned DEPTH = mrm_pkg::NOTICE_DEPTH_DEF,
  parameter int unsigned OFF_W = $clog2(mrm_pkg::RING_WORDS_DEF)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mrm_pkg::nq_ctrl_t            ctrl_i,
  input  logic [mrm_pkg::HALF_W-1:0]   push_type_i,
  input  logic [OFF_W-1:0]             push_off_i,
  output logic [$clog2(DEPTH+1)-1:0]   count_o,
  output logic [mrm_pkg::HALF_W-1:0]   front_type_o,
  output logic [OFF_W-1:0]             front_off_o,
  output logic [OFF_W-1:0]             next_off_o
);
  import mrm_pkg::*;

  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned NCW   = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = NCW + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  logic [HALF_W-1:0] type_q [DEPTH];
  logic [OFF_W-1:0]  off_q  [DEPTH];
  logic [IW-1:0]     head_q, head_d;
  logic [NCW-1:0]    count_q, count_d;
  logic [SUM_W-1:0]  tail_sum;
  logic [IW-1:0]     tail;
  logic              hit;
  logic [HALF_W-1:0] next_type;
  logic [OFF_W-1:0]  next_off;
  logic [HALF_W-1:0] front_type_q;
  logic [OFF_W-1:0]  front_off_q;

  always_comb begin
    tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
    if (tail_sum >= SUM_W'(DEPTH)) begin
      tail = IW'(tail_sum - SUM_W'(DEPTH));
    end else begin
      tail = IW'(tail_sum);
    end

    head_d  = head_q;
    count_d = count_q;
    if (ctrl_i.pop) begin
      head_d  = (head_q == LAST_IDX) ? '0 : head_q + IW'(1);
      count_d = count_q - NCW'(1);
    end else if (ctrl_i.push) begin
      count_d = count_q + NCW'(1);
    end

    // The entry that will sit at the head after this cycle, including one being pushed.
    hit       = ctrl_i.push && (tail == head_d);
    next_type = hit ? push_type_i : type_q[head_d];
    next_off  = hit ? push_off_i  : off_q[head_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      type_q[tail] <= push_type_i;
      off_q[tail]  <= push_off_i;
    end
    front_type_q <= next_type;
    front_off_q  <= next_off;
  end

  assign count_o      = count_q;
  assign front_type_o = front_type_q;
  assign front_off_o  = front_off_q;
  assign next_off_o   = next_off;

endmodule

/* design/message_ring_mailbox.sv */
// A word accepted into the input stage register is executed there once the output register
// can advance, and its response is registered in the output register.
// Throughput: one word per cycle while responses are taken; the ring memory gives one read and one write per cycle.
// Reset is asynchronous and active low; it clears the ring counters, the notice queue
// pointers and all transfer state. The ring memory is not cleared.
`timescale 1ns / 1ps

module message_ring_mailbox #(
  parameter int unsigned RING_WORDS   = mrm_pkg::RING_WORDS_DEF,
  parameter int unsigned NOTICE_DEPTH = mrm_pkg::NOTICE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mrm_in_if.sink    req_i,
  mrm_out_if.source rsp_o
);
  import mrm_pkg::*;

  localparam int unsigned AW  = $clog2(RING_WORDS);
  localparam int unsigned CW  = AW + 1;
  localparam int unsigned NCW = $clog2(NOTICE_DEPTH + 1);
  localparam logic [CALC_W-1:0] RW_C     = CALC_W'(RING_WORDS);
  localparam logic [CALC_W-1:0] TWO_RW_C = CALC_W'(2 * RING_WORDS);
  localparam logic [AW-1:0]     LAST_IDX = AW'(RING_WORDS - 1);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [CW-1:0] count_add(input logic [CW-1:0] c,
                                              input logic [SLOT_W-1:0] n);
    logic [CALC_W-1:0] s;
    s = CALC_W'(c) + CALC_W'(n);
    if (s >= TWO_RW_C) begin
      s = s - TWO_RW_C;
    end
    return CW'(s);
  endfunction

  // Handshake.
  logic in_acc, adv, exec;

  // Input stage.
  logic              s1_v_q;
  logic [KIND_W-1:0] s1_kind_q;
  logic [HALF_W-1:0] s1_type_q, s1_len_q, s1_maxl_q;
  logic [WORD_W-1:0] s1_data_q;

  // Mailbox state.
  logic [CW-1:0]     wcnt_q, wcnt_d, rcnt_q, rcnt_d;
  logic              send_act_q, send_act_d;
  logic [AW-1:0]     send_ptr_q, send_ptr_d;
  logic [SLOT_W-1:0] send_left_q, send_left_d;
  logic [HALF_W-1:0] send_type_q, send_type_d, send_len_q, send_len_d;
  logic              peek_v_q, peek_v_d;
  logic [HALF_W-1:0] peek_type_q, peek_type_d;
  logic [AW-1:0]     peek_off_q, peek_off_d;
  logic              recv_act_q, recv_act_d;
  logic [AW-1:0]     recv_ptr_q, recv_ptr_d;
  logic [HALF_W-1:0] recv_left_q, recv_left_d;
  logic [SLOT_W-1:0] recv_slot_q, recv_slot_d;

  // Output register.
  logic                out_v_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [HALF_W-1:0]   out_type_q, out_len_q;
  logic [WORD_W-1:0]   out_data_q;
  logic [VB_W-1:0]     out_vb_q;
  logic                out_last_q;

  // Execution.
  status_e           st;
  logic [HALF_W-1:0] res_type, res_len;
  logic [WORD_W-1:0] res_data;
  logic [VB_W-1:0]   res_vb;
  logic              res_last;
  logic [AW-1:0]     hoff;
  logic [CALC_W-1:0] used_raw, used, free_w;
  logic [SLOT_W-1:0] need, hslot, rc_amt;
  logic              publish, rc_step, got;
  logic [HALF_W-1:0] pub_len, pub_type, e_type, copy;
  logic [AW-1:0]     e_off;
  logic [VB_W-1:0]   vb;
  logic [WORD_W-1:0] mask;

  // Ring memory and notice queue.
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, rd_word;
  nq_ctrl_t          nq_ctrl;
  logic [HALF_W-1:0] nq_push_type, nq_front_type;
  logic [AW-1:0]     nq_push_off, nq_front_off, nq_next_off;
  logic [NCW-1:0]    nq_count;

  assign adv         = !out_v_q || rsp_o.ready;
  assign exec        = s1_v_q && adv;
  assign req_i.ready = !s1_v_q || adv;
  assign in_acc      = req_i.valid && req_i.ready;

  always_comb begin
    wcnt_d      = wcnt_q;
    rcnt_d      = rcnt_q;
    send_act_d  = send_act_q;
    send_ptr_d  = send_ptr_q;
    send_left_d = send_left_q;
    send_type_d = send_type_q;
    send_len_d  = send_len_q;
    peek_v_d    = peek_v_q;
    peek_type_d = peek_type_q;
    peek_off_d  = peek_off_q;
    recv_act_d  = recv_act_q;
    recv_ptr_d  = recv_ptr_q;
    recv_left_d = recv_left_q;
    recv_slot_d = recv_slot_q;

    st       = ST_SEQ;
    res_type = '0;
    res_len  = '0;
    res_data = '0;
    res_vb   = '0;
    res_last = 1'b0;

    mem_we       = 1'b0;
    mem_waddr    = send_ptr_q;
    mem_wdata    = s1_data_q;
    nq_ctrl      = '0;
    nq_push_type = send_type_q;

    hoff = (wcnt_q >= CW'(RING_WORDS)) ? AW'(wcnt_q - CW'(RING_WORDS)) : AW'(wcnt_q);
    nq_push_off = hoff;
    used_raw = CALC_W'(wcnt_q) + TWO_RW_C - CALC_W'(rcnt_q);
    used     = (used_raw >= TWO_RW_C) ? used_raw - TWO_RW_C : used_raw;
    free_w   = (used >= RW_C) ? '0 : RW_C - used;
    need     = slot_words(s1_len_q);

    publish  = 1'b0;
    pub_len  = send_len_q;
    pub_type = send_type_q;
    rc_step  = 1'b0;
    rc_amt   = recv_slot_q;
    got      = 1'b0;
    e_type   = peek_type_q;
    e_off    = peek_off_q;
    hslot    = slot_words(rd_word[WORD_W-1:HALF_W]);
    copy     = (rd_word[WORD_W-1:HALF_W] < s1_maxl_q) ? rd_word[WORD_W-1:HALF_W] : s1_maxl_q;
    vb       = (recv_left_q < HALF_W'(WORD_BYTES)) ? recv_left_q[VB_W-1:0] : VB_W'(WORD_BYTES);
    mask     = ~({WORD_W{1'b1}} << {vb, 3'b000});

    if (exec) begin
      case (s1_kind_q)
        KIND_SEND_BEGIN: begin
          if (!send_act_q) begin
            if (CALC_W'(need) > RW_C) begin
              st = ST_TOO_BIG;
            end else if (free_w < CALC_W'(need) || nq_count >= NCW'(NOTICE_DEPTH)) begin
              st = ST_RETRY;
            end else begin
              mem_we      = 1'b1;
              mem_waddr   = hoff;
              mem_wdata   = {s1_len_q, s1_type_q};
              send_act_d  = 1'b1;
              send_type_d = s1_type_q;
              send_len_d  = s1_len_q;
              send_ptr_d  = ptr_inc(hoff);
              send_left_d = need - SLOT_W'(1);
              if (need == SLOT_W'(1)) begin
                publish  = 1'b1;
                pub_len  = s1_len_q;
                pub_type = s1_type_q;
              end
              st = ST_OK;
            end
          end
        end
        KIND_SEND_WORD: begin
          if (send_act_q) begin
            mem_we     = 1'b1;
            send_ptr_d = ptr_inc(send_ptr_q);
            if (send_left_q != '0) begin
              send_left_d = send_left_q - SLOT_W'(1);
            end
            if (send_left_d == '0) begin
              publish = 1'b1;
            end
            st = ST_OK;
          end
        end
        KIND_PEEK: begin
          if (!peek_v_q && nq_count != '0) begin
            nq_ctrl.pop = 1'b1;
            peek_v_d    = 1'b1;
            peek_type_d = nq_front_type;
            peek_off_d  = nq_front_off;
          end
          if (peek_v_d) begin
            st       = ST_OK;
            res_type = peek_type_d;
          end else begin
            st = ST_EMPTY;
          end
        end
        KIND_RECV_BEGIN: begin
          if (!recv_act_q) begin
            if (peek_v_q) begin
              got      = 1'b1;
              peek_v_d = 1'b0;
            end else if (nq_count != '0) begin
              got         = 1'b1;
              nq_ctrl.pop = 1'b1;
              e_type      = nq_front_type;
              e_off       = nq_front_off;
            end
            if (!got) begin
              st = ST_EMPTY;
            end else if (rd_word[HALF_W-1:0] != e_type) begin
              st = ST_MISMATCH;
            end else begin
              st          = ST_OK;
              res_type    = rd_word[HALF_W-1:0];
              res_len     = rd_word[WORD_W-1:HALF_W];
              recv_slot_d = hslot;
              if (copy == '0) begin
                rc_step = 1'b1;
                rc_amt  = hslot;
              end else begin
                recv_act_d  = 1'b1;
                recv_ptr_d  = ptr_inc(e_off);
                recv_left_d = copy;
              end
            end
          end
        end
        KIND_RECV_WORD: begin
          if (recv_act_q) begin
            res_data    = rd_word & mask;
            res_vb      = vb;
            recv_left_d = recv_left_q - HALF_W'(vb);
            recv_ptr_d  = ptr_inc(recv_ptr_q);
            if (recv_left_d == '0) begin
              res_last   = 1'b1;
              recv_act_d = 1'b0;
              rc_step    = 1'b1;
            end
            st = ST_OK;
          end
        end
        default: begin
          st = ST_SEQ;
        end
      endcase

      if (publish) begin
        wcnt_d     = count_add(wcnt_q, slot_words(pub_len));
        send_act_d = 1'b0;
        if (nq_count < NCW'(NOTICE_DEPTH)) begin
          nq_ctrl.push = 1'b1;
          nq_push_type = pub_type;
        end
      end
      if (rc_step) begin
        rcnt_d = count_add(rcnt_q, rc_amt);
      end
    end
  end

  // The read for an incoming word is addressed from the state its predecessor leaves.
  assign mem_raddr = (req_i.kind == KIND_RECV_BEGIN) ? (peek_v_d ? peek_off_d : nq_next_off)
                                                     : recv_ptr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      out_v_q     <= 1'b0;
      wcnt_q      <= '0;
      rcnt_q      <= '0;
      send_act_q  <= 1'b0;
      send_ptr_q  <= '0;
      send_left_q <= '0;
      send_type_q <= '0;
      send_len_q  <= '0;
      peek_v_q    <= 1'b0;
      peek_type_q <= '0;
      peek_off_q  <= '0;
      recv_act_q  <= 1'b0;
      recv_ptr_q  <= '0;
      recv_left_q <= '0;
      recv_slot_q <= '0;
    end else begin
      if (in_acc) begin
        s1_v_q <= 1'b1;
      end else if (exec) begin
        s1_v_q <= 1'b0;
      end
      if (adv) begin
        out_v_q <= s1_v_q;
      end
      wcnt_q      <= wcnt_d;
      rcnt_q      <= rcnt_d;
      send_act_q  <= send_act_d;
      send_ptr_q  <= send_ptr_d;
      send_left_q <= send_left_d;
      send_type_q <= send_type_d;
      send_len_q  <= send_len_d;
      peek_v_q    <= peek_v_d;
      peek_type_q <= peek_type_d;
      peek_off_q  <= peek_off_d;
      recv_act_q  <= recv_act_d;
      recv_ptr_q  <= recv_ptr_d;
      recv_left_q <= recv_left_d;
      recv_slot_q <= recv_slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q <= req_i.kind;
      s1_type_q <= req_i.msg_type;
      s1_len_q  <= req_i.length;
      s1_maxl_q <= req_i.max_len;
      s1_data_q <= req_i.data;
    end
    if (exec) begin
      out_status_q <= st;
      out_type_q   <= res_type;
      out_len_q    <= res_len;
      out_data_q   <= res_data;
      out_vb_q     <= res_vb;
      out_last_q   <= res_last;
    end
  end

  assign rsp_o.valid        = out_v_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.msg_type_res = out_type_q;
  assign rsp_o.length_res   = out_len_q;
  assign rsp_o.data_res     = out_data_q;
  assign rsp_o.valid_bytes  = out_vb_q;
  assign rsp_o.last         = out_last_q;

  mrm_ring_ram #(
    .WORDS (RING_WORDS),
    .AW    (AW)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_acc),
    .raddr_i (mem_raddr),
    .rdata_o (rd_word)
  );

  mrm_notice_fifo #(
    .DEPTH (NOTICE_DEPTH),
    .OFF_W (AW)
  ) u_notice (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (nq_ctrl),
    .push_type_i  (nq_push_type),
    .push_off_i   (nq_push_off),
    .count_o      (nq_count),
    .front_type_o (nq_front_type),
    .front_off_o  (nq_front_off),
    .next_off_o   (nq_next_off)
  );

endmodule

/* design/mrm_checker.sv */
`timescale 1ns / 1ps

module mrm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [mrm_pkg::STATUS_W-1:0] status_i,
  input logic [mrm_pkg::VB_W-1:0]     valid_bytes_i,
  input logic                         last_i,
  input logic [mrm_pkg::WORD_W-1:0]   data_res_i
);
  import mrm_pkg::*;

  // A held response keeps its contents until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(data_res_i)
      && $stable(valid_bytes_i) && $stable(last_i))
    else $error("response changed while stalled");

  // Input is refused only while a response is held back and the input stage is full.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input refused without output back-pressure");

  // A new response traces back to an accepted word, registered through the input stage and the output register.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("response without a matching accepted word");

  // The final payload word carries data and a good status.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_i |-> status_i == ST_OK && valid_bytes_i != '0)
    else $error("last flag on a word that is not a delivered payload word");

endmodule

bind message_ring_mailbox mrm_checker u_mrm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .valid_bytes_i (rsp_o.valid_bytes),
  .last_i        (rsp_o.last),
  .data_res_i    (rsp_o.data_res)
);
